// ----- design/prts_pkg.sv -----
`timescale 1ns / 1ps

package prts_pkg;

	// Field widths fixed by the interface.
	localparam int ID_W   = 64;
	localparam int PRIO_W = 8;
	localparam int CNT_W  = 16;
	localparam int NUM_W  = 4;
	localparam int OP_W   = 2;
	localparam int KIND_W = 3;

	// Default sizing handed to the top level.
	localparam int SLOTS_DEF     = 16;
	localparam int MAX_BATCH_DEF = 8;

	localparam logic [NUM_W-1:0] BATCH_RESET = 4'd8;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_PUMP   = 2'd3;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_OK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PACKET   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE     = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              capture;
		logic              scan_step;
		logic              ins_write;
		logic              acc_write;
		logic              rem_write;
		logic              pump_start;
		logic              out_load;
		logic              emit_step;
		logic [KIND_W-1:0] out_kind;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            scan_at_end;
		logic            found;
		logic            free_avail;
		logic            sel_valid;
		logic            n_zero;
		logic            emit_last;
		logic            out_free;
	} status_t;

	// One slot record as held in the slot memory.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [CNT_W-1:0]  cnt;
	} slot_info_t;

endpackage

// ----- design/prts_ctrl.sv -----
`timescale 1ns / 1ps

module prts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  prts_pkg::status_t sts,
	output prts_pkg::cmd_t    cmd
);
	import prts_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [KIND_W-1:0] resp_kind_q, resp_kind_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		resp_kind_d = resp_kind_q;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_at_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_RESP;
				unique case (sts.op)
					OP_INSERT: begin
						if (sts.found) begin
							resp_kind_d = KIND_OK;
						end else if (sts.free_avail) begin
							cmd.ins_write = 1'b1;
							resp_kind_d   = KIND_OK;
						end else begin
							resp_kind_d = KIND_FULL;
						end
					end
					OP_ACCEPT, OP_REMOVE: begin
						if (!sts.found) begin
							resp_kind_d = KIND_NOTFOUND;
						end else begin
							cmd.acc_write = (sts.op == OP_ACCEPT);
							cmd.rem_write = (sts.op == OP_REMOVE);
							resp_kind_d   = KIND_OK;
						end
					end
					OP_PUMP: begin
						resp_kind_d = KIND_IDLE;
						if (sts.sel_valid) begin
							cmd.pump_start = 1'b1;
							if (!sts.n_zero) begin
								state_d = ST_EMIT;
							end
						end
					end
					default: begin
						resp_kind_d = KIND_IDLE;
					end
				endcase
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = resp_kind_q;
					state_d      = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_kind  = KIND_PACKET;
					cmd.emit_step = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			resp_kind_q <= KIND_OK;
		end else begin
			state_q     <= state_d;
			resp_kind_q <= resp_kind_d;
		end
	end

endmodule

// ----- design/prts_dp.sv -----
`timescale 1ns / 1ps

module prts_dp #(
	parameter int SLOTS     = prts_pkg::SLOTS_DEF,
	parameter int MAX_BATCH = prts_pkg::MAX_BATCH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prts_pkg::cmd_t                cmd,
	output prts_pkg::status_t             sts,
	input  logic                          cfg_we,
	input  logic [prts_pkg::NUM_W-1:0]    cfg_wdata,
	input  logic [prts_pkg::OP_W-1:0]     opcode,
	input  logic [prts_pkg::ID_W-1:0]     transfer_id,
	input  logic signed [prts_pkg::PRIO_W-1:0] priority_req,
	input  logic [prts_pkg::CNT_W-1:0]    packet_count,
	input  logic [prts_pkg::NUM_W-1:0]    link_space,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prts_pkg::KIND_W-1:0]   kind,
	output logic [prts_pkg::ID_W-1:0]     out_id,
	output logic [prts_pkg::CNT_W-1:0]    packet_index,
	output logic                          transfer_done,
	output logic                          last
);
	import prts_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
	localparam logic [6:0] MB7 = 7'(MAX_BATCH);

	// Slot memories and per-slot flags.
	slot_info_t       info_mem [SLOTS];
	logic [CNT_W-1:0] next_mem [SLOTS];
	logic [SLOTS-1:0] valid_q, acc_q;

	// Captured request and configuration.
	logic [OP_W-1:0]   req_op_q;
	logic [ID_W-1:0]   req_id_q;
	logic [PRIO_W-1:0] req_prio_q;
	logic [CNT_W-1:0]  req_cnt_q;
	logic [NUM_W-1:0]  req_space_q;
	logic [NUM_W-1:0]  batch_q;
	logic [ID_W-1:0]   last_served_q;

	// Scan read stage.
	logic [IW-1:0]     scan_cnt_q;
	logic              ev_s1;
	slot_info_t        rd_info_s1;
	logic [CNT_W-1:0]  rd_next_s1;
	logic              rd_v_s1, rd_a_s1;
	logic [IW-1:0]     rd_idx_s1;

	// Scan results.
	logic              found_q, free_q;
	logic [IW-1:0]     found_idx_q, free_idx_q;
	logic              have_first_q, have_best_q;
	logic [PRIO_W-1:0] top_prio_q;
	logic [IW-1:0]     first_idx_q, best_idx_q;
	logic [ID_W-1:0]   first_id_q, best_id_q;
	logic [CNT_W-1:0]  first_cnt_q, best_cnt_q, first_next_q, best_next_q;

	// Emission state.
	logic [ID_W-1:0]   em_id_q;
	logic [CNT_W-1:0]  em_idx_q, em_cnt_q;
	logic [NUM_W-1:0]  em_left_q;

	logic              out_valid_q;

	logic              elig;
	logic [IW-1:0]     sel_idx;
	logic [ID_W-1:0]   sel_id;
	logic [CNT_W-1:0]  sel_cnt, sel_next, sel_left;
	logic [NUM_W-1:0]  lim_c, space_c, ls_min, n_pkts;

	assign elig = rd_v_s1 && rd_a_s1 && (rd_next_s1 < rd_info_s1.cnt);

	// The round-robin pick wins when a higher id exists in the top band.
	assign sel_idx  = have_best_q ? best_idx_q  : first_idx_q;
	assign sel_id   = have_best_q ? best_id_q   : first_id_q;
	assign sel_cnt  = have_best_q ? best_cnt_q  : first_cnt_q;
	assign sel_next = have_best_q ? best_next_q : first_next_q;
	assign sel_left = sel_cnt - sel_next;

	always_comb begin
		if (batch_q == '0) begin
			lim_c = NUM_W'(1);
		end else if ({3'b000, batch_q} > MB7) begin
			lim_c = NUM_W'(MAX_BATCH);
		end else begin
			lim_c = batch_q;
		end
		if ({3'b000, req_space_q} > MB7) begin
			space_c = NUM_W'(MAX_BATCH);
		end else begin
			space_c = req_space_q;
		end
		ls_min = (space_c < lim_c) ? space_c : lim_c;
		n_pkts = (sel_left < CNT_W'(ls_min)) ? sel_left[NUM_W-1:0] : ls_min;
	end

	assign sts.op          = req_op_q;
	assign sts.scan_at_end = (scan_cnt_q == LAST_SLOT);
	assign sts.found       = found_q;
	assign sts.free_avail  = free_q;
	assign sts.sel_valid   = have_first_q;
	assign sts.n_zero      = (n_pkts == '0);
	assign sts.emit_last   = (em_left_q == NUM_W'(1));
	assign sts.out_free    = !out_valid_q || out_ready;

	// Memory writes: at most one slot changes per item.
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			info_mem[free_idx_q] <= '{id: req_id_q, prio: req_prio_q, cnt: req_cnt_q};
		end
		if (cmd.ins_write) begin
			next_mem[free_idx_q] <= '0;
		end else if (cmd.acc_write) begin
			next_mem[found_idx_q] <= '0;
		end else if (cmd.pump_start) begin
			next_mem[sel_idx] <= sel_next + CNT_W'(n_pkts);
		end
	end

	// Registered memory read for the scan.
	always_ff @(posedge clk) begin
		rd_info_s1 <= info_mem[scan_cnt_q];
		rd_next_s1 <= next_mem[scan_cnt_q];
		rd_v_s1    <= valid_q[scan_cnt_q];
		rd_a_s1    <= acc_q[scan_cnt_q];
		rd_idx_s1  <= scan_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			acc_q         <= '0;
			batch_q       <= BATCH_RESET;
			last_served_q <= '0;
			scan_cnt_q    <= '0;
			ev_s1         <= 1'b0;
			found_q       <= 1'b0;
			free_q        <= 1'b0;
			have_first_q  <= 1'b0;
			have_best_q   <= 1'b0;
			em_left_q     <= '0;
			em_idx_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				batch_q <= cfg_wdata;
			end
			ev_s1 <= cmd.scan_step;

			if (cmd.capture) begin
				scan_cnt_q   <= '0;
				found_q      <= 1'b0;
				free_q       <= 1'b0;
				have_first_q <= 1'b0;
				have_best_q  <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_cnt_q <= scan_cnt_q + IW'(1);
			end

			if (ev_s1) begin
				if (rd_v_s1 && !found_q && (rd_info_s1.id == req_id_q)) begin
					found_q     <= 1'b1;
					found_idx_q <= rd_idx_s1;
				end
				if (!rd_v_s1 && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
				if (elig) begin
					if (!have_first_q ||
					    ($signed(rd_info_s1.prio) > $signed(top_prio_q))) begin
						// A new top band restarts both picks.
						have_first_q <= 1'b1;
						top_prio_q   <= rd_info_s1.prio;
						first_idx_q  <= rd_idx_s1;
						first_id_q   <= rd_info_s1.id;
						first_cnt_q  <= rd_info_s1.cnt;
						first_next_q <= rd_next_s1;
						have_best_q  <= (rd_info_s1.id > last_served_q);
						best_idx_q   <= rd_idx_s1;
						best_id_q    <= rd_info_s1.id;
						best_cnt_q   <= rd_info_s1.cnt;
						best_next_q  <= rd_next_s1;
					end else if (rd_info_s1.prio == top_prio_q) begin
						if (rd_info_s1.id < first_id_q) begin
							first_idx_q  <= rd_idx_s1;
							first_id_q   <= rd_info_s1.id;
							first_cnt_q  <= rd_info_s1.cnt;
							first_next_q <= rd_next_s1;
						end
						if ((rd_info_s1.id > last_served_q) &&
						    (!have_best_q || (rd_info_s1.id < best_id_q))) begin
							have_best_q <= 1'b1;
							best_idx_q  <= rd_idx_s1;
							best_id_q   <= rd_info_s1.id;
							best_cnt_q  <= rd_info_s1.cnt;
							best_next_q <= rd_next_s1;
						end
					end
				end
			end

			if (cmd.ins_write) begin
				valid_q[free_idx_q] <= 1'b1;
				acc_q[free_idx_q]   <= 1'b0;
			end
			if (cmd.acc_write) begin
				acc_q[found_idx_q] <= 1'b1;
			end
			if (cmd.rem_write) begin
				valid_q[found_idx_q] <= 1'b0;
				acc_q[found_idx_q]   <= 1'b0;
			end

			if (cmd.pump_start) begin
				last_served_q <= sel_id;
				em_idx_q      <= sel_next;
				em_left_q     <= n_pkts;
			end else if (cmd.emit_step) begin
				em_idx_q  <= em_idx_q + CNT_W'(1);
				em_left_q <= em_left_q - NUM_W'(1);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q    <= opcode;
			req_id_q    <= transfer_id;
			req_prio_q  <= priority_req;
			req_cnt_q   <= packet_count;
			req_space_q <= link_space;
		end
		if (cmd.pump_start) begin
			em_id_q  <= sel_id;
			em_cnt_q <= sel_cnt;
		end
		if (cmd.out_load) begin
			kind <= cmd.out_kind;
			case (cmd.out_kind)
				KIND_PACKET: begin
					out_id        <= em_id_q;
					packet_index  <= em_idx_q;
					transfer_done <= ((em_idx_q + CNT_W'(1)) == em_cnt_q);
					last          <= (em_left_q == NUM_W'(1));
				end
				KIND_IDLE: begin
					out_id        <= '0;
					packet_index  <= '0;
					transfer_done <= 1'b0;
					last          <= 1'b1;
				end
				default: begin
					out_id        <= req_id_q;
					packet_index  <= '0;
					transfer_done <= 1'b0;
					last          <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/priority_round_robin_transfer_scheduler.sv -----
`timescale 1ns / 1ps
// A new word is taken only when the previous one has loaded its last result into the output
// register; the slot memory is scanned one entry per cycle through its single read port.
// Reset (arst_n, asynchronous, active low) clears all slot valid and accepted flags, the last
// served id and the output valid, and sets the batch limit to 8. Slot memories are not cleared.

module priority_round_robin_transfer_scheduler #(
	parameter int SLOTS     = prts_pkg::SLOTS_DEF,
	parameter int MAX_BATCH = prts_pkg::MAX_BATCH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [prts_pkg::NUM_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [prts_pkg::OP_W-1:0]          opcode,
	input  logic [prts_pkg::ID_W-1:0]          transfer_id,
	input  logic signed [prts_pkg::PRIO_W-1:0] priority_req,
	input  logic [prts_pkg::CNT_W-1:0]         packet_count,
	input  logic [prts_pkg::NUM_W-1:0]         link_space,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [prts_pkg::KIND_W-1:0]        kind,
	output logic [prts_pkg::ID_W-1:0]          out_id,
	output logic [prts_pkg::CNT_W-1:0]         packet_index,
	output logic                               transfer_done,
	output logic                               last
);
	import prts_pkg::*;

	// The controller walks each word through capture, a full scan of the slot table, a drain state,
	// a decision state and then one or more results. The datapath holds the slot memories, tracks
	// the lowest matching and free slots during the scan, and keeps the two candidates of the
	// highest priority band: the smallest id overall and the smallest id above the last one
	// served. The second one wins when it exists, which gives the round-robin tie break.
	// Results sit in an output register, so the scan of the next word is never held up by a
	// result that the consumer has not taken yet.

	cmd_t    cmd;
	status_t sts;

	prts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	prts_dp #(
		.SLOTS     (SLOTS),
		.MAX_BATCH (MAX_BATCH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.opcode        (opcode),
		.transfer_id   (transfer_id),
		.priority_req  (priority_req),
		.packet_count  (packet_count),
		.link_space    (link_space),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.out_id        (out_id),
		.packet_index  (packet_index),
		.transfer_done (transfer_done),
		.last          (last)
	);

endmodule
